### rtl/core/cmcl_pkg.sv
// ----------------------------------------------------------------------------
// cmcl_pkg
// Shared types and constants of the cascaded motor control law.
// ----------------------------------------------------------------------------
`default_nettype none

package cmcl_pkg;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POSITION_GAIN       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CASCADE_GAIN        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_GAIN       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TORQUE_CONSTANT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TORQUE_LIMIT        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_LIMIT      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_POSITION_LOW_LIMIT  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_POSITION_HIGH_LIMIT = 3'd7;

    // reset values
    localparam logic [31:0] RST_POSITION_GAIN       = 32'd50267;
    localparam logic [31:0] RST_CASCADE_GAIN        = 32'd0;
    localparam logic [31:0] RST_VELOCITY_GAIN       = 32'd0;
    localparam logic [15:0] RST_TORQUE_CONSTANT     = 16'd256;
    localparam logic [19:0] RST_TORQUE_LIMIT        = 20'd20000;
    localparam logic [22:0] RST_VELOCITY_LIMIT      = 23'd130379;
    localparam logic [31:0] RST_POSITION_LOW_LIMIT  = 32'h8000_0000;
    localparam logic [31:0] RST_POSITION_HIGH_LIMIT = 32'h7FFF_FFFF;

    typedef enum logic [2:0] {
        MODE_IDLE      = 3'd0,
        MODE_TORQUE    = 3'd1,
        MODE_VELOCITY  = 3'd2,
        MODE_POSITION  = 3'd3,
        MODE_IMPEDANCE = 3'd4
    } t_mode;

    typedef struct packed {
        logic [31:0] position_gain;
        logic [31:0] cascade_gain;
        logic [31:0] velocity_gain;
        logic [15:0] torque_constant;
        logic [19:0] torque_limit;
        logic [22:0] velocity_limit;
        logic [31:0] position_low_limit;
        logic [31:0] position_high_limit;
    } t_cfg;

endpackage

`default_nettype wire

### rtl/core/cmcl_cfg_regs.sv
// ----------------------------------------------------------------------------
// cmcl_cfg_regs
// Configuration register file: index decode, width masking and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module cmcl_cfg_regs (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [cmcl_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [cmcl_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output cmcl_pkg::t_cfg                         o_cfg
);

    cmcl_pkg::t_cfg r_cfg;
    cmcl_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                cmcl_pkg::REG_POSITION_GAIN:       n_cfg.position_gain       = i_cfg_data;
                cmcl_pkg::REG_CASCADE_GAIN:        n_cfg.cascade_gain        = i_cfg_data;
                cmcl_pkg::REG_VELOCITY_GAIN:       n_cfg.velocity_gain       = i_cfg_data;
                cmcl_pkg::REG_TORQUE_CONSTANT:     n_cfg.torque_constant     = i_cfg_data[15:0];
                cmcl_pkg::REG_TORQUE_LIMIT:        n_cfg.torque_limit        = i_cfg_data[19:0];
                cmcl_pkg::REG_VELOCITY_LIMIT:      n_cfg.velocity_limit      = i_cfg_data[22:0];
                cmcl_pkg::REG_POSITION_LOW_LIMIT:  n_cfg.position_low_limit  = i_cfg_data;
                cmcl_pkg::REG_POSITION_HIGH_LIMIT: n_cfg.position_high_limit = i_cfg_data;
                default:                           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.position_gain       <= cmcl_pkg::RST_POSITION_GAIN;
            r_cfg.cascade_gain        <= cmcl_pkg::RST_CASCADE_GAIN;
            r_cfg.velocity_gain       <= cmcl_pkg::RST_VELOCITY_GAIN;
            r_cfg.torque_constant     <= cmcl_pkg::RST_TORQUE_CONSTANT;
            r_cfg.torque_limit        <= cmcl_pkg::RST_TORQUE_LIMIT;
            r_cfg.velocity_limit      <= cmcl_pkg::RST_VELOCITY_LIMIT;
            r_cfg.position_low_limit  <= cmcl_pkg::RST_POSITION_LOW_LIMIT;
            r_cfg.position_high_limit <= cmcl_pkg::RST_POSITION_HIGH_LIMIT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### rtl/core/cascaded_motor_control_law_top.sv
// ----------------------------------------------------------------------------
// cascaded_motor_control_law_top
// Cascaded position/velocity proportional control law, one tick per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   A control tick is taken at a rising edge with start high and busy low.
//   busy stays low: the pipeline takes a new tick in every cycle.
//   Each tick gives one current setpoint and saturation flag, shown for one
//   cycle with o_done high once the tick has passed the register stages.
//   Results leave in tick order at the input rate, one per cycle at most.
//   Seven register stages: input clamps and position error, gain products,
//   rounding and velocity error, velocity gain product, torque select and
//   clamp, torque constant product, output rounding and saturation. Each
//   product is a single multiplier of at most 32 by 33 bits.
//   Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data at once,
//   with no read-back; they should change only while no tick is in flight.
//   Synchronous reset clears the pipeline valid bits and loads the register
//   reset values. The receiver cannot stall: every strobed result is a
//   completed transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module cascaded_motor_control_law_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [2:0]                        i_mode,
    input  wire logic signed [31:0]                i_position,
    input  wire logic signed [23:0]                i_velocity,
    input  wire logic signed [31:0]                i_position_target,
    input  wire logic signed [23:0]                i_speed_target,
    input  wire logic signed [20:0]                i_torque_target,
    input  wire logic                              i_cfg_we,
    input  wire logic [cmcl_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [cmcl_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                                   o_done,
    output logic signed [20:0]                     o_current_setpoint,
    output logic                                   o_saturated
);

    localparam logic signed [29:0] CUR_MAX = 30'sd1048575;
    localparam logic signed [29:0] CUR_MIN = -30'sd1048576;

    cmcl_pkg::t_cfg cfg;

    cmcl_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    assign busy = 1'b0;

    // common register views
    logic signed [31:0] kp, kpv, kv, plo, phi;
    logic signed [24:0] vmax_s;
    logic signed [48:0] vmax_w;
    logic signed [49:0] tmax_w;
    logic signed [16:0] kt_s;

    assign kp     = $signed(cfg.position_gain);
    assign kpv    = $signed(cfg.cascade_gain);
    assign kv     = $signed(cfg.velocity_gain);
    assign plo    = $signed(cfg.position_low_limit);
    assign phi    = $signed(cfg.position_high_limit);
    assign vmax_s = $signed({2'b00, cfg.velocity_limit});
    assign vmax_w = $signed({26'd0, cfg.velocity_limit});
    assign tmax_w = $signed({30'd0, cfg.torque_limit});
    assign kt_s   = $signed({1'b0, cfg.torque_constant});

    // ---------------- stage 1: target clamps and position error ----------------
    logic signed [31:0] n_s1_pt_lo, n_s1_pt;
    logic signed [24:0] n_s1_vt_w;
    logic signed [23:0] n_s1_vtc;
    logic signed [32:0] n_s1_pos_err;

    logic               r_s1_valid;
    logic [2:0]         r_s1_mode;
    logic signed [23:0] r_s1_vel;
    logic signed [20:0] r_s1_trq;
    logic signed [23:0] r_s1_vtc;
    logic signed [32:0] r_s1_pos_err;

    always_comb begin
        // raise to low first, then lower to high, so high wins when crossed
        n_s1_pt_lo   = (i_position_target < plo) ? plo : i_position_target;
        n_s1_pt      = (n_s1_pt_lo > phi) ? phi : n_s1_pt_lo;
        n_s1_pos_err = $signed({i_position[31], i_position}) - $signed({n_s1_pt[31], n_s1_pt});
        n_s1_vt_w    = $signed({i_speed_target[23], i_speed_target});
        if (n_s1_vt_w > vmax_s) begin
            n_s1_vt_w = vmax_s;
        end else if (n_s1_vt_w < -vmax_s) begin
            n_s1_vt_w = -vmax_s;
        end
        n_s1_vtc = n_s1_vt_w[23:0];
    end

    // ---------------- stage 2: gain products on the position error -------------
    logic signed [64:0] n_s2_kp_prod, n_s2_kpv_prod;

    logic               r_s2_valid;
    logic [2:0]         r_s2_mode;
    logic signed [23:0] r_s2_vel;
    logic signed [20:0] r_s2_trq;
    logic signed [23:0] r_s2_vtc;
    logic signed [64:0] r_s2_kp_prod;
    logic signed [64:0] r_s2_kpv_prod;

    assign n_s2_kp_prod  = kp  * r_s1_pos_err;
    assign n_s2_kpv_prod = kpv * r_s1_pos_err;

    // ---------------- stage 3: rounding, cascade clamp, velocity error ---------
    // round to nearest, ties away from zero: add half, less one when negative
    logic signed [65:0] n_s3_kp_sum, n_s3_kpv_sum;
    logic signed [65:0] n_s3_kp_shr, n_s3_kpv_shr;
    logic signed [48:0] n_s3_kp_rnd, n_s3_kpv_rnd;
    logic signed [48:0] n_s3_kp_term;
    logic signed [48:0] n_s3_vt;
    logic signed [23:0] n_s3_vref;
    logic signed [24:0] n_s3_vel_err;

    logic               r_s3_valid;
    logic [2:0]         r_s3_mode;
    logic signed [20:0] r_s3_trq;
    logic signed [48:0] r_s3_kp_term;
    logic signed [24:0] r_s3_vel_err;

    always_comb begin
        n_s3_kp_sum  = $signed({r_s2_kp_prod[64], r_s2_kp_prod})
                     + (r_s2_kp_prod[64] ? 66'sd32767 : 66'sd32768);
        n_s3_kpv_sum = $signed({r_s2_kpv_prod[64], r_s2_kpv_prod})
                     + (r_s2_kpv_prod[64] ? 66'sd32767 : 66'sd32768);
        n_s3_kp_shr  = n_s3_kp_sum  >>> 16;
        n_s3_kpv_shr = n_s3_kpv_sum >>> 16;
        n_s3_kp_rnd  = n_s3_kp_shr[48:0];
        n_s3_kpv_rnd = n_s3_kpv_shr[48:0];
        // gains act on the negated error
        n_s3_kp_term = -n_s3_kp_rnd;
        n_s3_vt      = -n_s3_kpv_rnd;
        if (n_s3_vt > vmax_w) begin
            n_s3_vt = vmax_w;
        end else if (n_s3_vt < -vmax_w) begin
            n_s3_vt = -vmax_w;
        end
        if (cmcl_pkg::t_mode'(r_s2_mode) == cmcl_pkg::MODE_POSITION) begin
            n_s3_vref = n_s3_vt[23:0];
        end else begin
            n_s3_vref = r_s2_vtc;
        end
        n_s3_vel_err = $signed({r_s2_vel[23], r_s2_vel}) - $signed({n_s3_vref[23], n_s3_vref});
    end

    // ---------------- stage 4: velocity gain product ----------------------------
    logic signed [56:0] n_s4_kv_prod;

    logic               r_s4_valid;
    logic [2:0]         r_s4_mode;
    logic signed [20:0] r_s4_trq;
    logic signed [48:0] r_s4_kp_term;
    logic signed [56:0] r_s4_kv_prod;

    assign n_s4_kv_prod = kv * r_s3_vel_err;

    // ---------------- stage 5: torque select and clamp --------------------------
    logic signed [57:0] n_s5_kv_sum, n_s5_kv_shr;
    logic signed [40:0] n_s5_kv_rnd, n_s5_kv_term;
    logic signed [49:0] n_s5_torque;
    logic signed [20:0] n_s5_trq_c;
    logic               n_s5_sat;

    logic               r_s5_valid;
    logic signed [20:0] r_s5_torque;
    logic               r_s5_sat;

    always_comb begin
        n_s5_kv_sum  = $signed({r_s4_kv_prod[56], r_s4_kv_prod})
                     + (r_s4_kv_prod[56] ? 58'sd32767 : 58'sd32768);
        n_s5_kv_shr  = n_s5_kv_sum >>> 16;
        n_s5_kv_rnd  = n_s5_kv_shr[40:0];
        n_s5_kv_term = -n_s5_kv_rnd;
        case (cmcl_pkg::t_mode'(r_s4_mode))
            cmcl_pkg::MODE_TORQUE:    n_s5_torque = {{29{r_s4_trq[20]}}, r_s4_trq};
            cmcl_pkg::MODE_VELOCITY,
            cmcl_pkg::MODE_POSITION:  n_s5_torque = {{9{n_s5_kv_term[40]}}, n_s5_kv_term};
            cmcl_pkg::MODE_IMPEDANCE: n_s5_torque = $signed({r_s4_kp_term[48], r_s4_kp_term})
                                                  + $signed({{9{n_s5_kv_term[40]}}, n_s5_kv_term});
            default:                  n_s5_torque = '0;
        endcase
        n_s5_sat = 1'b0;
        if (n_s5_torque > tmax_w) begin
            n_s5_torque = tmax_w;
            n_s5_sat    = 1'b1;
        end else if (n_s5_torque < -tmax_w) begin
            n_s5_torque = -tmax_w;
            n_s5_sat    = 1'b1;
        end
        n_s5_trq_c = n_s5_torque[20:0];
    end

    // ---------------- stage 6: torque constant product --------------------------
    logic signed [37:0] n_s6_cur_prod;

    logic               r_s6_valid;
    logic signed [37:0] r_s6_cur_prod;
    logic               r_s6_sat;

    assign n_s6_cur_prod = kt_s * r_s5_torque;

    // ---------------- stage 7: Q8.8 rounding and output saturation --------------
    logic signed [38:0] n_s7_sum, n_s7_shr;
    logic signed [29:0] n_s7_cur;
    logic signed [20:0] n_s7_out;
    logic               n_s7_sat;

    logic               r_done;
    logic signed [20:0] r_current_setpoint;
    logic               r_saturated;

    always_comb begin
        n_s7_sum = $signed({r_s6_cur_prod[37], r_s6_cur_prod})
                 + (r_s6_cur_prod[37] ? 39'sd127 : 39'sd128);
        n_s7_shr = n_s7_sum >>> 8;
        n_s7_cur = n_s7_shr[29:0];
        n_s7_sat = r_s6_sat;
        if (n_s7_cur > CUR_MAX) begin
            n_s7_cur = CUR_MAX;
            n_s7_sat = 1'b1;
        end else if (n_s7_cur < CUR_MIN) begin
            n_s7_cur = CUR_MIN;
            n_s7_sat = 1'b1;
        end
        n_s7_out = n_s7_cur[20:0];
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
            r_s6_valid <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_s1_valid <= start && !busy;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
            r_s5_valid <= r_s4_valid;
            r_s6_valid <= r_s5_valid;
            r_done     <= r_s6_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_s1_mode          <= i_mode;
        r_s1_vel           <= i_velocity;
        r_s1_trq           <= i_torque_target;
        r_s1_vtc           <= n_s1_vtc;
        r_s1_pos_err       <= n_s1_pos_err;

        r_s2_mode          <= r_s1_mode;
        r_s2_vel           <= r_s1_vel;
        r_s2_trq           <= r_s1_trq;
        r_s2_vtc           <= r_s1_vtc;
        r_s2_kp_prod       <= n_s2_kp_prod;
        r_s2_kpv_prod      <= n_s2_kpv_prod;

        r_s3_mode          <= r_s2_mode;
        r_s3_trq           <= r_s2_trq;
        r_s3_kp_term       <= n_s3_kp_term;
        r_s3_vel_err       <= n_s3_vel_err;

        r_s4_mode          <= r_s3_mode;
        r_s4_trq           <= r_s3_trq;
        r_s4_kp_term       <= r_s3_kp_term;
        r_s4_kv_prod       <= n_s4_kv_prod;

        r_s5_torque        <= n_s5_trq_c;
        r_s5_sat           <= n_s5_sat;

        r_s6_cur_prod      <= n_s6_cur_prod;
        r_s6_sat           <= r_s5_sat;

        r_current_setpoint <= n_s7_out;
        r_saturated        <= n_s7_sat;
    end

    assign o_done             = r_done;
    assign o_current_setpoint = r_current_setpoint;
    assign o_saturated        = r_saturated;

endmodule

`default_nettype wire

### bench/cascaded_motor_control_law_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cascaded_motor_control_law_top_tb
// Self-checking bench for the cascaded position/velocity control law. Control
// ticks are sent under reset, directed and random register settings with
// random idle gaps; each strobed current setpoint and saturation flag is
// compared against an in-bench fixed-point predictor of the law.
// ----------------------------------------------------------------------------

module cascaded_motor_control_law_top_tb;

    localparam int PIPE_LATENCY    = 7;
    localparam int STALL_LIMIT     = 500;
    localparam int RANDOM_PHASES   = 8;
    localparam int TICKS_PER_PHASE = 178;

    // mode codes past impedance are spare and behave as idle
    localparam logic [2:0] MODE_RSVD_5 = 3'd5;
    localparam logic [2:0] MODE_RSVD_6 = 3'd6;
    localparam logic [2:0] MODE_RSVD_7 = 3'd7;

    localparam longint POS_MAX      = 64'sd2147483647;
    localparam longint POS_MIN      = -64'sd2147483648;
    localparam longint VEL_MAX      = 64'sd8388607;
    localparam longint VEL_MIN      = -64'sd8388608;
    localparam longint TRQ_MAX      = 64'sd1048575;
    localparam longint TRQ_MIN      = -64'sd1048576;
    localparam longint SETPOINT_MAX = 64'sd1048575;
    localparam longint SETPOINT_MIN = -64'sd1048576;

    localparam cmcl_pkg::t_cfg RESET_CFG = '{
        position_gain:       cmcl_pkg::RST_POSITION_GAIN,
        cascade_gain:        cmcl_pkg::RST_CASCADE_GAIN,
        velocity_gain:       cmcl_pkg::RST_VELOCITY_GAIN,
        torque_constant:     cmcl_pkg::RST_TORQUE_CONSTANT,
        torque_limit:        cmcl_pkg::RST_TORQUE_LIMIT,
        velocity_limit:      cmcl_pkg::RST_VELOCITY_LIMIT,
        position_low_limit:  cmcl_pkg::RST_POSITION_LOW_LIMIT,
        position_high_limit: cmcl_pkg::RST_POSITION_HIGH_LIMIT
    };

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] position;
        logic [23:0] velocity;
        logic [31:0] position_target;
        logic [23:0] speed_target;
        logic [20:0] torque_target;
    } t_tick;

    typedef struct packed {
        logic [20:0] current;
        logic        saturated;
    } t_setpoint;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            start = 1'b0;
    logic                            busy;
    logic [2:0]                      i_mode = cmcl_pkg::MODE_IDLE;
    logic signed [31:0]              i_position = '0;
    logic signed [23:0]              i_velocity = '0;
    logic signed [31:0]              i_position_target = '0;
    logic signed [23:0]              i_speed_target = '0;
    logic signed [20:0]              i_torque_target = '0;
    logic                            i_cfg_we = 1'b0;
    logic [cmcl_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [cmcl_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                            o_done;
    logic signed [20:0]              o_current_setpoint;
    logic                            o_saturated;

    cmcl_pkg::t_cfg law_cfg;
    t_setpoint      pending_setpoints[$];
    int             errors = 0;
    int             stall_cycles = 0;

    cascaded_motor_control_law_top dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_mode             (i_mode),
        .i_position         (i_position),
        .i_velocity         (i_velocity),
        .i_position_target  (i_position_target),
        .i_speed_target     (i_speed_target),
        .i_torque_target    (i_torque_target),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .o_done             (o_done),
        .o_current_setpoint (o_current_setpoint),
        .o_saturated        (o_saturated)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // (a * b) / 2^shift, rounded to nearest with ties away from zero
    function automatic longint q_round(input longint a, input longint b, input int shift);
        longint      p;
        logic [63:0] m;
        p = a * b;
        m = (p < 0) ? 64'(-p) : 64'(p);
        m = (m + (64'd1 << (shift - 1))) >> shift;
        return (p < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint clip_sym(input longint x, input longint lim);
        if (x > lim)
            return lim;
        if (x < -lim)
            return -lim;
        return x;
    endfunction

    function automatic t_setpoint control_law_setpoint(input t_tick tk,
                                                       input cmcl_pkg::t_cfg c);
        longint    pos, vel, pos_t, vel_t, trq_t;
        longint    kp, kpv, kv, kt, tmax, vmax, plo, phi;
        longint    pos_err, vel_cmd, torque, cur;
        t_setpoint res;
        pos   = longint'($signed(tk.position));
        vel   = longint'($signed(tk.velocity));
        pos_t = longint'($signed(tk.position_target));
        vel_t = longint'($signed(tk.speed_target));
        trq_t = longint'($signed(tk.torque_target));
        kp    = longint'($signed(c.position_gain));
        kpv   = longint'($signed(c.cascade_gain));
        kv    = longint'($signed(c.velocity_gain));
        kt    = longint'(c.torque_constant);
        tmax  = longint'(c.torque_limit);
        vmax  = longint'(c.velocity_limit);
        plo   = longint'($signed(c.position_low_limit));
        phi   = longint'($signed(c.position_high_limit));
        res.saturated = 1'b0;

        // crossed limits: raise to low first, then lower to high
        if (pos_t < plo)
            pos_t = plo;
        if (pos_t > phi)
            pos_t = phi;
        pos_err = pos - pos_t;

        case (tk.mode)
            cmcl_pkg::MODE_TORQUE: begin
                torque = trq_t;
            end
            cmcl_pkg::MODE_VELOCITY: begin
                torque = q_round(kv, -(vel - clip_sym(vel_t, vmax)), 16);
            end
            cmcl_pkg::MODE_POSITION: begin
                vel_cmd = q_round(kpv, -pos_err, 16);
                torque  = q_round(kv, -(vel - clip_sym(vel_cmd, vmax)), 16);
            end
            cmcl_pkg::MODE_IMPEDANCE: begin
                torque = q_round(kp, -pos_err, 16)
                       + q_round(kv, -(vel - clip_sym(vel_t, vmax)), 16);
            end
            default: begin
                torque = 0;
            end
        endcase

        if (torque > tmax || torque < -tmax)
            res.saturated = 1'b1;
        torque = clip_sym(torque, tmax);

        cur = q_round(kt, torque, 8);
        if (cur > SETPOINT_MAX) begin
            cur = SETPOINT_MAX;
            res.saturated = 1'b1;
        end
        if (cur < SETPOINT_MIN) begin
            cur = SETPOINT_MIN;
            res.saturated = 1'b1;
        end
        res.current = cur[20:0];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // signed value for a field of the given width: extremes, full range or small
    function automatic logic [31:0] rand_signed(input int width);
        logic [31:0] lim;
        logic [31:0] v;
        int          k;
        lim = 32'h1 << (width - 1);
        case ($urandom_range(9))
            0: v = lim - 32'd1;
            1: v = lim;
            2: v = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
            3, 4, 5: v = $urandom;
            default: begin
                k = $urandom_range(width - 2, 0);
                v = $urandom & ((32'h1 << k) - 32'd1);
                if ($urandom_range(1))
                    v = -v;
            end
        endcase
        return v;
    endfunction

    function automatic logic [31:0] rand_unsigned(input int width);
        logic [31:0] v;
        int          k;
        case ($urandom_range(7))
            0: v = '0;
            1: v = (32'h1 << width) - 32'd1;
            default: begin
                k = $urandom_range(width, 1);
                v = $urandom & ((32'h1 << k) - 32'd1);
            end
        endcase
        return v;
    endfunction

    // Q16.16 gain, mostly of a usable size
    function automatic logic [31:0] rand_gain();
        logic [31:0] v;
        if ($urandom_range(9) < 6) begin
            v = $urandom & ((32'h1 << $urandom_range(22, 4)) - 32'd1);
            if ($urandom_range(1))
                v = -v;
        end else begin
            v = rand_signed(32);
        end
        return v;
    endfunction

    function automatic int rand_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    function automatic cmcl_pkg::t_cfg random_cfg();
        cmcl_pkg::t_cfg c;
        logic [31:0]    lo;
        c.position_gain   = rand_gain();
        c.cascade_gain    = rand_gain();
        c.velocity_gain   = rand_gain();
        c.torque_constant = 16'(rand_unsigned(16));
        c.torque_limit    = 20'(rand_unsigned(20));
        c.velocity_limit  = 23'(rand_unsigned(23));
        case ($urandom_range(4))
            0, 1: begin
                c.position_low_limit  = cmcl_pkg::RST_POSITION_LOW_LIMIT;
                c.position_high_limit = cmcl_pkg::RST_POSITION_HIGH_LIMIT;
            end
            2: begin
                lo = -($urandom & 32'h000F_FFFF);
                c.position_low_limit  = lo;
                c.position_high_limit = lo + ($urandom & 32'h001F_FFFF);
            end
            3: begin
                c.position_low_limit  = rand_signed(32);
                c.position_high_limit = rand_signed(32);
            end
            default: begin
                lo = $urandom & 32'h0000_FFFF;
                c.position_low_limit  = lo;
                c.position_high_limit = lo - ($urandom & 32'h0000_FFFF);
            end
        endcase
        return c;
    endfunction

    function automatic t_tick make_tick(input logic [2:0] mode, input longint pos,
                                        input longint vel, input longint pos_t,
                                        input longint vel_t, input longint trq);
        t_tick tk;
        tk.mode            = mode;
        tk.position        = pos[31:0];
        tk.velocity        = vel[23:0];
        tk.position_target = pos_t[31:0];
        tk.speed_target    = vel_t[23:0];
        tk.torque_target   = trq[20:0];
        return tk;
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    task automatic send_tick(input t_tick tk, input int gap);
        start             <= 1'b1;
        i_mode            <= tk.mode;
        i_position        <= tk.position;
        i_velocity        <= tk.velocity;
        i_position_target <= tk.position_target;
        i_speed_target    <= tk.speed_target;
        i_torque_target   <= tk.torque_target;
        forever begin
            @(posedge i_clk);
            if (busy === 1'b0)
                break;
        end
        pending_setpoints.push_back(control_law_setpoint(tk, law_cfg));
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // hold off until every pending setpoint is out and the pipeline is empty
    task automatic wait_drained();
        start <= 1'b0;
        while (pending_setpoints.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_LATENCY + 1) @(posedge i_clk);
    endtask

    task automatic load_config(input cmcl_pkg::t_cfg c);
        logic [cmcl_pkg::CFG_IDX_W-1:0]  idx;
        logic [cmcl_pkg::CFG_DATA_W-1:0] data;
        for (int i = 0; i < 8; i++) begin
            idx  = cmcl_pkg::CFG_IDX_W'(i);
            // narrow registers get junk above their width
            data = $urandom;
            case (idx)
                cmcl_pkg::REG_POSITION_GAIN:       data = c.position_gain;
                cmcl_pkg::REG_CASCADE_GAIN:        data = c.cascade_gain;
                cmcl_pkg::REG_VELOCITY_GAIN:       data = c.velocity_gain;
                cmcl_pkg::REG_TORQUE_CONSTANT:     data[15:0] = c.torque_constant;
                cmcl_pkg::REG_TORQUE_LIMIT:        data[19:0] = c.torque_limit;
                cmcl_pkg::REG_VELOCITY_LIMIT:      data[22:0] = c.velocity_limit;
                cmcl_pkg::REG_POSITION_LOW_LIMIT:  data = c.position_low_limit;
                cmcl_pkg::REG_POSITION_HIGH_LIMIT: data = c.position_high_limit;
                default:                           data = '0;
            endcase
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx;
            i_cfg_data <= data;
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        law_cfg = c;
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    task automatic test_reset_values();
        send_tick(make_tick(cmcl_pkg::MODE_IDLE, POS_MAX, VEL_MIN, POS_MIN, VEL_MAX, TRQ_MAX),
                  rand_gap());
        send_tick(make_tick(cmcl_pkg::MODE_TORQUE, 0, 0, 0, 0, 1234), rand_gap());
        send_tick(make_tick(cmcl_pkg::MODE_TORQUE, 0, 0, 0, 0, TRQ_MAX), rand_gap());
        send_tick(make_tick(cmcl_pkg::MODE_TORQUE, 0, 0, 0, 0, TRQ_MIN), rand_gap());
        send_tick(make_tick(cmcl_pkg::MODE_TORQUE, 0, 0, 0, 0, 0), rand_gap());
        send_tick(make_tick(cmcl_pkg::MODE_VELOCITY, 0, VEL_MAX, 0, VEL_MIN, 0), rand_gap());
        send_tick(make_tick(cmcl_pkg::MODE_POSITION, POS_MAX, 0, POS_MIN, 0, 0), rand_gap());
        send_tick(make_tick(cmcl_pkg::MODE_IMPEDANCE, POS_MIN, 0, POS_MAX, 0, 0), rand_gap());
        send_tick(make_tick(cmcl_pkg::MODE_IMPEDANCE, 3, 0, 0, 0, 0), rand_gap());
        send_tick(make_tick(MODE_RSVD_5, 0, 0, 0, 0, 555), rand_gap());
        send_tick(make_tick(MODE_RSVD_6, 1, 2, 3, 4, 555), rand_gap());
        send_tick(make_tick(MODE_RSVD_7, 1, 2, 3, 4, TRQ_MIN), rand_gap());
    endtask

    // half gains give exact ties; low limit above high limit
    task automatic test_rounding_and_crossed_limits();
        cmcl_pkg::t_cfg c;
        c = '{position_gain: 32'h0001_0000, cascade_gain: 32'h0000_8000,
              velocity_gain: 32'h0000_8000, torque_constant: 16'hFFFF,
              torque_limit: 20'hF_FFFF, velocity_limit: 23'h7F_FFFF,
              position_low_limit: 32'd100, position_high_limit: -32'sd100};
        wait_drained();
        load_config(c);
        send_tick(make_tick(cmcl_pkg::MODE_VELOCITY, 0, 1, 0, 0, 0), rand_gap());
        send_tick(make_tick(cmcl_pkg::MODE_VELOCITY, 0, -1, 0, 0, 0), rand_gap());
        send_tick(make_tick(cmcl_pkg::MODE_VELOCITY, 0, VEL_MIN, 0, VEL_MAX, 0), rand_gap());
        send_tick(make_tick(cmcl_pkg::MODE_POSITION, 5, 0, 0, 0, 0), rand_gap());
        send_tick(make_tick(cmcl_pkg::MODE_IMPEDANCE, 150, 4, 0, 1, 0), rand_gap());
        send_tick(make_tick(cmcl_pkg::MODE_TORQUE, 0, 0, 0, 0, TRQ_MAX), rand_gap());
        send_tick(make_tick(cmcl_pkg::MODE_TORQUE, 0, 0, 0, 0, TRQ_MIN), rand_gap());
        send_tick(make_tick(cmcl_pkg::MODE_TORQUE, 0, 0, 0, 0, 1), rand_gap());
        send_tick(make_tick(cmcl_pkg::MODE_TORQUE, 0, 0, 0, 0, -3), rand_gap());
    endtask

    task automatic test_zero_and_extreme_limits();
        cmcl_pkg::t_cfg c;
        c = '{position_gain: 32'h8000_0000, cascade_gain: 32'h8000_0000,
              velocity_gain: 32'h7FFF_FFFF, torque_constant: 16'h0000,
              torque_limit: 20'h0_0000, velocity_limit: 23'h00_0000,
              position_low_limit: 32'd7, position_high_limit: 32'd7};
        wait_drained();
        load_config(c);
        send_tick(make_tick(cmcl_pkg::MODE_TORQUE, 0, 0, 0, 0, 5), rand_gap());
        send_tick(make_tick(cmcl_pkg::MODE_TORQUE, 0, 0, 0, 0, 0), rand_gap());
        send_tick(make_tick(cmcl_pkg::MODE_VELOCITY, 0, 10, 0, VEL_MAX, 0), rand_gap());
        send_tick(make_tick(cmcl_pkg::MODE_POSITION, POS_MAX, VEL_MIN, POS_MIN, 0, 0),
                  rand_gap());
        send_tick(make_tick(cmcl_pkg::MODE_IMPEDANCE, POS_MIN, VEL_MAX, POS_MAX, VEL_MIN, 0), 0);
    endtask

    task automatic test_random_ticks();
        cmcl_pkg::t_cfg c;
        t_tick          tk;
        bit             steady;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            c = (phase == 0) ? RESET_CFG : random_cfg();
            wait_drained();
            load_config(c);
            // some phases run back to back with no gaps
            steady = (phase % 3 == 1);
            for (int n = 0; n < TICKS_PER_PHASE; n++) begin
                case ($urandom_range(19))
                    0: tk.mode = cmcl_pkg::MODE_IDLE;
                    1: tk.mode = 3'($urandom_range(MODE_RSVD_7, MODE_RSVD_5));
                    default: tk.mode = 3'($urandom_range(cmcl_pkg::MODE_IMPEDANCE,
                                                         cmcl_pkg::MODE_TORQUE));
                endcase
                tk.position = rand_signed(32);
                tk.velocity = 24'(rand_signed(24));
                // targets near the measured values half the time so the law stays in range
                if ($urandom_range(1))
                    tk.position_target = tk.position + 32'($urandom_range(4096)) - 32'd2048;
                else
                    tk.position_target = rand_signed(32);
                if ($urandom_range(1))
                    tk.speed_target = tk.velocity + 24'($urandom_range(8192)) - 24'd4096;
                else
                    tk.speed_target = 24'(rand_signed(24));
                tk.torque_target = 21'(rand_signed(21));
                send_tick(tk, steady ? 0 : rand_gap());
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // result check and watchdog
    // ------------------------------------------------------------------------

    always @(posedge i_clk) begin : check_setpoints
        t_setpoint want;
        if (i_rst_n && o_done === 1'b1) begin
            if (pending_setpoints.size() == 0) begin
                $display("%0t: setpoint with none pending, got %0d sat %0b",
                         $time, o_current_setpoint, o_saturated);
                errors++;
            end else begin
                want = pending_setpoints.pop_front();
                if (o_current_setpoint !== want.current) begin
                    $display("%0t: current setpoint mismatch, expected %0d, got %0d",
                             $time, $signed(want.current), o_current_setpoint);
                    errors++;
                end
                if (o_saturated !== want.saturated) begin
                    $display("%0t: saturated flag mismatch, expected %0b, got %0b",
                             $time, want.saturated, o_saturated);
                    errors++;
                end
            end
        end
    end

    // no transfer on either side for too long means the block hung
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && busy === 1'b0) || o_done === 1'b1) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("[cascaded_motor_control_law_top] ERROR");
                $finish;
            end
        end
    end

    initial begin
        law_cfg = RESET_CFG;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_values();
        test_rounding_and_crossed_limits();
        test_zero_and_extreme_limits();
        test_random_ticks();
        wait_drained();
        if (errors == 0)
            $display("[cascaded_motor_control_law_top] OK");
        else
            $display("[cascaded_motor_control_law_top] ERROR");
        $finish;
    end

endmodule
